/* hdl/usb_control_endpoint_responder_core_macros.svh */
// Assertion macros for the endpoint-zero control responder.
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_CORE_MACROS_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_CORE_MACROS_SVH

// Checked outside reset.
`define UCER_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define UCER_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* hdl/ucer_pkg.sv */
// Shared types, codes and descriptor table for the endpoint-zero responder.
package ucer_pkg;

    localparam logic [1:0] STAGE_SETUP      = 2'd0;
    localparam logic [1:0] STAGE_IN_DATA    = 2'd1;
    localparam logic [1:0] STAGE_IN_STATUS  = 2'd2;
    localparam logic [1:0] STAGE_OUT_STATUS = 2'd3;

    localparam logic [1:0] KIND_SETUP   = 2'd0;
    localparam logic [1:0] KIND_STATUS2 = 2'd1;
    localparam logic [1:0] KIND_STATUS3 = 2'd2;
    localparam logic [1:0] KIND_DATA    = 2'd3;

    localparam logic [7:0] REQ_SET_ADDRESS    = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;

    localparam logic [3:0] DEV_EVT_BUS_RESET    = 4'd1;
    localparam logic [3:0] DEV_EVT_CONNECT_DONE = 4'd2;
    localparam logic [3:0] EP_EVT_XFER_DONE     = 4'd1;

    localparam logic [7:0] DTYPE_DEVICE = 8'd1;
    localparam logic [7:0] DTYPE_CONFIG = 8'd2;
    localparam logic [7:0] DTYPE_STRING = 8'd3;

    localparam logic [2:0] DESC_NONE     = 3'd0;
    localparam logic [2:0] DESC_DEVICE   = 3'd1;
    localparam logic [2:0] DESC_CONFIG   = 3'd2;
    localparam logic [2:0] DESC_LANGUAGE = 3'd3;
    localparam logic [2:0] DESC_MAKER    = 3'd4;
    localparam logic [2:0] DESC_PRODUCT  = 3'd5;
    localparam logic [2:0] DESC_SERIAL   = 3'd6;

    localparam logic [5:0] SETUP_LEN    = 6'd8;
    localparam logic [5:0] MAX_DESC_LEN = 6'd34;

    typedef struct packed {
        logic [31:0] event_word;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } t_request;

    typedef struct packed {
        logic       endpoint;
        logic [1:0] transfer_kind;
        logic [5:0] transfer_length;
        logic [2:0] descriptor_id;
        logic       address_write;
        logic [6:0] device_address;
    } t_result;

    typedef struct packed {
        logic [2:0] id;
        logic [5:0] length;
    } t_desc;

    function automatic t_desc desc_lookup(input logic [15:0] value);
        t_desc d;
        d = '{id: DESC_NONE, length: 6'd0};
        unique case (value[15:8])
            DTYPE_DEVICE: begin
                d = '{id: DESC_DEVICE, length: 6'd18};
            end
            DTYPE_CONFIG: begin
                d = '{id: DESC_CONFIG, length: 6'd18};
            end
            DTYPE_STRING: begin
                unique case (value[7:0])
                    8'd0:    d = '{id: DESC_LANGUAGE, length: 6'd4};
                    8'd1:    d = '{id: DESC_MAKER, length: 6'd34};
                    8'd2:    d = '{id: DESC_PRODUCT, length: 6'd18};
                    8'd3:    d = '{id: DESC_SERIAL, length: 6'd22};
                    default: d = '{id: DESC_NONE, length: 6'd0};
                endcase
            end
            default: begin
                d = '{id: DESC_NONE, length: 6'd0};
            end
        endcase
        return d;
    endfunction

endpackage

/* hdl/ucer_in_reg.sv */
// Input register: captures one request and holds it until the control stage takes it.
module ucer_in_reg
    import ucer_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_request i_req,
    input  logic     i_take,
    output logic     o_stall,
    output logic     o_valid,
    output t_request o_req
);

    logic     r_valid;
    t_request r_req;

    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

/* hdl/ucer_ctrl.sv */
// Control-stage state, event decode and result selection.
module ucer_ctrl
    import ucer_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_request i_req,
    output logic     o_emit,
    output t_result  o_res
);

    logic [1:0] r_stage, n_stage;
    logic       r_addr_pend, n_addr_pend;
    logic [6:0] r_pend_addr, n_pend_addr;

    logic       is_dev;
    logic [3:0] dev_type;
    logic [4:0] ep_num;
    logic [3:0] ep_type;
    t_desc      desc;
    logic       desc_hit;
    logic [5:0] resp_len;
    logic [2:0] resp_id;

    assign is_dev   = i_req.event_word[0];
    assign dev_type = i_req.event_word[11:8];
    assign ep_num   = i_req.event_word[5:1];
    assign ep_type  = i_req.event_word[9:6];
    assign desc     = desc_lookup(i_req.request_value);
    assign desc_hit = (i_req.request_code == REQ_GET_DESCRIPTOR) && (desc.id != DESC_NONE);

    always_comb begin
        resp_id  = DESC_NONE;
        resp_len = 6'd0;
        if (desc_hit) begin
            resp_id  = desc.id;
            resp_len = (i_req.request_length < {10'd0, desc.length}) ?
                       i_req.request_length[5:0] : desc.length;
        end
    end

    always_comb begin
        n_stage     = r_stage;
        n_addr_pend = r_addr_pend;
        n_pend_addr = r_pend_addr;
        o_emit      = 1'b0;
        o_res       = '{endpoint: 1'b0, transfer_kind: KIND_SETUP, transfer_length: 6'd0,
                        descriptor_id: DESC_NONE, address_write: 1'b0,
                        device_address: 7'd0};
        if (is_dev) begin
            if (dev_type == DEV_EVT_BUS_RESET || dev_type == DEV_EVT_CONNECT_DONE) begin
                n_addr_pend           = 1'b0;
                n_stage               = STAGE_SETUP;
                o_emit                = 1'b1;
                o_res.transfer_length = SETUP_LEN;
            end
        end else if (ep_type == EP_EVT_XFER_DONE) begin
            unique case (r_stage)
                STAGE_SETUP: begin
                    if (ep_num == 5'd0) begin
                        o_emit = 1'b1;
                        if (desc_hit) begin
                            n_addr_pend = 1'b0;
                        end else if (i_req.request_code == REQ_SET_ADDRESS) begin
                            n_addr_pend = 1'b1;
                            n_pend_addr = i_req.request_value[6:0];
                        end
                        o_res.endpoint = 1'b1;
                        if (i_req.request_type[7] && resp_len != 6'd0) begin
                            n_stage               = STAGE_IN_DATA;
                            o_res.transfer_kind   = KIND_DATA;
                            o_res.transfer_length = resp_len;
                            o_res.descriptor_id   = resp_id;
                        end else begin
                            n_stage             = STAGE_IN_STATUS;
                            o_res.transfer_kind = KIND_STATUS2;
                        end
                    end
                end
                STAGE_IN_DATA: begin
                    if (ep_num == 5'd1) begin
                        o_emit              = 1'b1;
                        n_stage             = STAGE_OUT_STATUS;
                        o_res.transfer_kind = KIND_STATUS3;
                    end
                end
                STAGE_IN_STATUS, STAGE_OUT_STATUS: begin
                    if (ep_num == ((r_stage == STAGE_IN_STATUS) ? 5'd1 : 5'd0)) begin
                        o_emit                = 1'b1;
                        n_stage               = STAGE_SETUP;
                        n_addr_pend           = 1'b0;
                        o_res.transfer_length = SETUP_LEN;
                        o_res.address_write   = r_addr_pend;
                        o_res.device_address  = r_addr_pend ? r_pend_addr : 7'd0;
                    end
                end
                default: begin
                    n_stage = STAGE_SETUP;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= STAGE_SETUP;
            r_addr_pend <= 1'b0;
            r_pend_addr <= 7'd0;
        end else if (i_fire) begin
            r_stage     <= n_stage;
            r_addr_pend <= n_addr_pend;
            r_pend_addr <= n_pend_addr;
        end
    end

endmodule

/* hdl/ucer_out_reg.sv */
// Output register: holds one transfer request until the consumer takes it.
module ucer_out_reg
    import ucer_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* hdl/usb_control_endpoint_responder_core.sv */
// Endpoint-zero control responder: takes one controller event per cycle while the
// output is not stalled, and posts the next control transfer. A request passes
// through one input register, then the stage decode and descriptor table feeding
// the output register. One request is accepted every
// cycle while the output is not stalled; the control-stage registers update as a
// request passes from the input register to the output register, so back-to-back
// events see each other's effect. Events that cause no transfer are consumed with
// no result. Stall on the output backs up through the input register.
module usb_control_endpoint_responder_core
    import ucer_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_event_word,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic [15:0] i_request_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_endpoint,
    output logic [1:0]  o_transfer_kind,
    output logic [5:0]  o_transfer_length,
    output logic [2:0]  o_descriptor_id,
    output logic        o_address_write,
    output logic [6:0]  o_device_address
);

    t_request req_in, req_q;
    t_result  res_d, res_q;
    logic     req_valid, out_ready, fire, emit;

    assign req_in = '{event_word: i_event_word, request_type: i_request_type,
                      request_code: i_request_code, request_value: i_request_value,
                      request_length: i_request_length};

    ucer_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (req_in),
        .i_take  (out_ready),
        .o_stall (o_stall),
        .o_valid (req_valid),
        .o_req   (req_q)
    );

    assign fire = req_valid && out_ready;

    ucer_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (req_q),
        .o_emit  (emit),
        .o_res   (res_d)
    );

    ucer_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && emit),
        .i_res   (res_d),
        .i_stall (i_stall),
        .o_ready (out_ready),
        .o_valid (o_valid),
        .o_res   (res_q)
    );

    assign o_endpoint        = res_q.endpoint;
    assign o_transfer_kind   = res_q.transfer_kind;
    assign o_transfer_length = res_q.transfer_length;
    assign o_descriptor_id   = res_q.descriptor_id;
    assign o_address_write   = res_q.address_write;
    assign o_device_address  = res_q.device_address;

endmodule

/* hdl/ucer_checker.sv */
// Port-level checks for the endpoint-zero responder, bound to the top level.
`include "usb_control_endpoint_responder_core_macros.svh"

module ucer_checker
    import ucer_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_endpoint,
    input logic [1:0] o_transfer_kind,
    input logic [5:0] o_transfer_length,
    input logic [2:0] o_descriptor_id,
    input logic       o_address_write,
    input logic [6:0] o_device_address
);

    `UCER_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid, "result valid after reset")
    `UCER_ASSERT(a_out_hold, o_valid && i_stall |=> o_valid && $stable(o_transfer_kind) && $stable(o_transfer_length) && $stable(o_device_address), "stalled result changed")
    `UCER_ASSERT(a_desc_only_data, o_valid && o_transfer_kind != KIND_DATA |-> o_descriptor_id == DESC_NONE, "descriptor on non-data transfer")
    `UCER_ASSERT(a_addr_on_setup, o_valid && o_address_write |-> o_transfer_kind == KIND_SETUP && !o_endpoint && o_transfer_length == SETUP_LEN, "address write outside setup re-arm")
    `UCER_ASSERT(a_data_shape, o_valid && o_transfer_kind == KIND_DATA |-> o_endpoint && o_transfer_length != 6'd0 && o_transfer_length <= MAX_DESC_LEN, "bad data transfer")

endmodule

bind usb_control_endpoint_responder_core ucer_checker u_ucer_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_endpoint        (o_endpoint),
    .o_transfer_kind   (o_transfer_kind),
    .o_transfer_length (o_transfer_length),
    .o_descriptor_id   (o_descriptor_id),
    .o_address_write   (o_address_write),
    .o_device_address  (o_device_address)
);
